### hw/rtl/dtq_pkg.sv
// ============================================================================
// dtq_pkg: shared constants and types for the deadline timer queue
// Sizes of the timer table, field widths, opcodes, status codes and the
// sequencer states.
// ============================================================================
package dtq_pkg;

  // Table size and derived index and count widths.
  localparam int MAX_TIMERS = 16;
  localparam int IDX_W      = $clog2(MAX_TIMERS);
  localparam int CNT_W      = $clog2(MAX_TIMERS + 1);

  // Field widths.
  localparam int TIME_BITS = 32;
  localparam int DELAY_W   = 16;
  localparam int CB_W      = 8;

  // Operation codes of an input beat.
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_POLL   = 2'd2
  } opcode_t;

  // Status codes of a result beat.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_UNUSED = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } state_t;

endpackage

### hw/rtl/deadline_timer_queue.sv
// ============================================================================
// deadline_timer_queue: timeout queue kept sorted by deadline
// Adds timeouts at now plus delay behind all equal or earlier deadlines,
// cancels them by handle and fires the head entry once it is due.
// ============================================================================
//
//   channel | direction | signals
//   --------+-----------+-------------------------------------------------
//   in      | input     | in_valid, in_ready, opcode, now, delay,
//           |           | callback_id, handle
//   out     | output    | out_valid, out_ready, status, slot, fired,
//           |           | fired_callback
//
// An add walks past p queued entries (p from 0 to MAX_TIMERS - 1) with equal
// or earlier deadlines; a cancel walks the order list up to the position of
// the handle; a poll of a non-empty queue looks only at the head entry; a
// poll of an empty queue and rejected or unknown operations skip the scan.
// The single deadline comparator walks the order list one position per
// cycle.
// After reset the queue is empty and a beat can be taken as soon as reset is released.
// A new beat is taken while a finished result still waits on the output; the
// block then holds its next result until the output register frees up.

module deadline_timer_queue (
  input  logic                           clk,
  input  logic                           rst,
  // Input channel.
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     opcode,
  input  logic [dtq_pkg::TIME_BITS-1:0]  now,
  input  logic [dtq_pkg::DELAY_W-1:0]    delay,
  input  logic [dtq_pkg::CB_W-1:0]       callback_id,
  input  logic [dtq_pkg::IDX_W-1:0]      handle,
  // Output channel.
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     status,
  output logic [dtq_pkg::IDX_W-1:0]      slot,
  output logic                           fired,
  output logic [dtq_pkg::CB_W-1:0]       fired_callback
);

  // Sequencer and operation registers.
  dtq_pkg::state_t                  state, state_next;
  dtq_pkg::opcode_t                 op;
  logic [dtq_pkg::TIME_BITS-1:0]    key;
  logic [dtq_pkg::CB_W-1:0]         cb_r;
  logic [dtq_pkg::IDX_W-1:0]        hnd;
  logic [dtq_pkg::IDX_W-1:0]        new_slot;
  logic [dtq_pkg::CNT_W-1:0]        pos;
  logic [dtq_pkg::CNT_W-1:0]        count;

  // Timer table and order list.
  logic [dtq_pkg::TIME_BITS-1:0]    deadline [dtq_pkg::MAX_TIMERS];
  logic [dtq_pkg::CB_W-1:0]         callback [dtq_pkg::MAX_TIMERS];
  logic [dtq_pkg::IDX_W-1:0]        order    [dtq_pkg::MAX_TIMERS];
  logic [dtq_pkg::MAX_TIMERS-1:0]   used;

  // Result waiting for the output register.
  logic [1:0]                       res_status, res_status_next;
  logic [dtq_pkg::IDX_W-1:0]        res_slot, res_slot_next;
  logic                             res_fired, res_fired_next;
  logic [dtq_pkg::CB_W-1:0]         res_cb, res_cb_next;

  // Control decisions of the sequencer.
  logic                             accept;
  logic                             finish;
  logic                             step;
  logic                             ins;
  logic                             del;
  logic                             rel;
  logic                             out_load;
  logic [dtq_pkg::IDX_W-1:0]        rel_idx;

  // Shared compare unit and helpers.
  logic [dtq_pkg::IDX_W-1:0]        cur;
  logic [dtq_pkg::TIME_BITS-1:0]    cur_dl;
  logic                             le;
  logic                             at_end;
  logic                             handle_ok;
  logic [dtq_pkg::IDX_W-1:0]        free_idx;
  logic                             free_any;
  logic [dtq_pkg::TIME_BITS-1:0]    key_in;

  // No beat is taken while reset is held.
  assign in_ready = (state == dtq_pkg::S_IDLE) && !rst;
  assign accept   = in_valid && in_ready;

  // Deadline of an add beat, or the poll time.
  assign key_in = (opcode == dtq_pkg::OP_POLL) ? now
                                               : now + dtq_pkg::TIME_BITS'(delay);

  // The one comparator: deadline at the scanned order position against the key.
  assign cur    = order[pos[dtq_pkg::IDX_W-1:0]];
  assign cur_dl = deadline[cur];
  assign le     = (cur_dl <= key);
  assign at_end = (pos == count);

  assign handle_ok = (dtq_pkg::CNT_W'(handle) < dtq_pkg::CNT_W'(dtq_pkg::MAX_TIMERS));
  assign rel_idx   = (op == dtq_pkg::OP_POLL) ? cur : hnd;

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = dtq_pkg::MAX_TIMERS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_idx = dtq_pkg::IDX_W'(i);
        free_any = 1'b1;
      end
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control decisions.
  always_comb begin
    state_next      = state;
    finish          = 1'b0;
    step            = 1'b0;
    ins             = 1'b0;
    del             = 1'b0;
    rel             = 1'b0;
    out_load        = 1'b0;
    res_status_next = dtq_pkg::ST_OK;
    res_slot_next   = '0;
    res_fired_next  = 1'b0;
    res_cb_next     = '0;
    unique case (state)
      dtq_pkg::S_IDLE: begin
        if (accept) begin
          case (dtq_pkg::opcode_t'(opcode))
            dtq_pkg::OP_ADD: begin
              if (count >= dtq_pkg::CNT_W'(dtq_pkg::MAX_TIMERS) || !free_any) begin
                res_status_next = dtq_pkg::ST_FULL;
                finish          = 1'b1;
              end else begin
                state_next = dtq_pkg::S_SCAN;
              end
            end
            dtq_pkg::OP_CANCEL: begin
              if (!handle_ok || !used[handle]) begin
                res_status_next = dtq_pkg::ST_UNUSED;
                finish          = 1'b1;
              end else begin
                state_next = dtq_pkg::S_SCAN;
              end
            end
            dtq_pkg::OP_POLL: begin
              if (count == '0) begin
                finish = 1'b1;
              end else begin
                state_next = dtq_pkg::S_SCAN;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      dtq_pkg::S_SCAN: begin
        case (op)
          dtq_pkg::OP_ADD: begin
            // Stop at the first later deadline or at the tail.
            if (at_end || !le) begin
              ins           = 1'b1;
              res_slot_next = new_slot;
              finish        = 1'b1;
            end else begin
              step = 1'b1;
            end
          end
          dtq_pkg::OP_CANCEL: begin
            if (at_end) begin
              rel    = 1'b1;
              finish = 1'b1;
            end else if (cur == hnd) begin
              del    = 1'b1;
              rel    = 1'b1;
              finish = 1'b1;
            end else begin
              step = 1'b1;
            end
          end
          dtq_pkg::OP_POLL: begin
            // Only the head entry is looked at.
            if (le) begin
              del            = 1'b1;
              rel            = 1'b1;
              res_slot_next  = cur;
              res_fired_next = 1'b1;
              res_cb_next    = callback[cur];
            end
            finish = 1'b1;
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end
      dtq_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = dtq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dtq_pkg::S_IDLE;
      end
    endcase
    if (finish) begin
      state_next = dtq_pkg::S_DONE;
    end
  end

  // Control registers: count, slot usage, scan position and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      used      <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        pos <= '0;
      end else if (step) begin
        pos <= pos + 1'b1;
      end
      if (ins) begin
        count          <= count + 1'b1;
        used[new_slot] <= 1'b1;
      end else if (del) begin
        count <= count - 1'b1;
      end
      if (rel) begin
        used[rel_idx] <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Operation fields captured on an input beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= dtq_pkg::opcode_t'(opcode);
      key      <= key_in;
      cb_r     <= callback_id;
      hnd      <= handle;
      new_slot <= free_idx;
    end
  end

  // New entry and order list moves: open a gap on insert, close it on removal.
  always_ff @(posedge clk) begin
    if (ins) begin
      deadline[new_slot] <= key;
      callback[new_slot] <= cb_r;
      for (int i = 1; i < dtq_pkg::MAX_TIMERS; i++) begin
        if (dtq_pkg::CNT_W'(i) > pos) begin
          order[i] <= order[i-1];
        end
      end
      order[pos[dtq_pkg::IDX_W-1:0]] <= new_slot;
    end else if (del) begin
      for (int i = 0; i < dtq_pkg::MAX_TIMERS - 1; i++) begin
        if (dtq_pkg::CNT_W'(i) >= pos) begin
          order[i] <= order[i+1];
        end
      end
    end
  end

  // Result hold register and output register.
  always_ff @(posedge clk) begin
    if (finish) begin
      res_status <= res_status_next;
      res_slot   <= res_slot_next;
      res_fired  <= res_fired_next;
      res_cb     <= res_cb_next;
    end
    if (out_load) begin
      status         <= res_status;
      slot           <= res_slot;
      fired          <= res_fired;
      fired_callback <= res_cb;
    end
  end

`ifndef SYNTHESIS
  // The pending count never exceeds the table size.
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= dtq_pkg::CNT_W'(dtq_pkg::MAX_TIMERS))
    else $error("pending count above table size");

  // The number of used slots equals the pending count.
  a_used_count: assert property (@(posedge clk) disable iff (rst)
    $countones(used) == int'(count))
    else $error("used slots disagree with pending count");

  // The scan never runs past the tail of the order list.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == dtq_pkg::S_SCAN |-> pos <= count)
    else $error("scan position beyond pending count");

  // A fired beat always reports ok, and a beat that did not fire has no callback.
  a_fired_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && fired |-> status == dtq_pkg::ST_OK)
    else $error("fired beat with error status");

  a_no_fire_cb: assert property (@(posedge clk) disable iff (rst)
    out_valid && !fired |-> fired_callback == '0)
    else $error("callback reported without firing");
`endif

endmodule

### verif/tb.sv
// ============================================================================
// tb: testbench for the deadline timer queue
// Drives add, cancel and poll beats, keeps its own copy of the timer table
// and the deadline order, and checks every result beat field by field under
// several mixes of sender gaps and receiver stalls.
// ============================================================================
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcode value with no defined operation.
  localparam logic [1:0] OP_UNDEF = 2'd3;

  localparam int LAT_PAUSE        = 40;
  localparam int IDLE_LIMIT       = 4000;
  localparam int HOLD_CYCLES      = 300;
  localparam int RANDOM_PER_PHASE = 300;

  // One result beat as the block reports it.
  typedef struct packed {
    dtq_pkg::status_t            status;
    logic [dtq_pkg::IDX_W-1:0]   slot;
    logic                        fired;
    logic [dtq_pkg::CB_W-1:0]    fired_cb;
  } timer_result_t;

  logic                           clk;
  logic                           rst            = 1'b1;
  logic                           in_valid       = 1'b0;
  logic                           in_ready;
  logic [1:0]                     opcode         = '0;
  logic [dtq_pkg::TIME_BITS-1:0]  now            = '0;
  logic [dtq_pkg::DELAY_W-1:0]    delay          = '0;
  logic [dtq_pkg::CB_W-1:0]       callback_id    = '0;
  logic [dtq_pkg::IDX_W-1:0]      handle         = '0;
  logic                           out_valid;
  logic                           out_ready      = 1'b0;
  logic [1:0]                     status;
  logic [dtq_pkg::IDX_W-1:0]      slot;
  logic                           fired;
  logic [dtq_pkg::CB_W-1:0]       fired_callback;

  // Shadow of the timer table and of the deadline order.
  logic [dtq_pkg::TIME_BITS-1:0]  slot_deadline [dtq_pkg::MAX_TIMERS];
  logic [dtq_pkg::CB_W-1:0]       slot_callback [dtq_pkg::MAX_TIMERS];
  bit                             slot_used     [dtq_pkg::MAX_TIMERS];
  logic [dtq_pkg::IDX_W-1:0]      deadline_order[$];

  timer_result_t                  timer_answers[$];
  timer_result_t                  got;
  int                             err_cnt;
  int                             send_idle_pct;
  int                             rx_stall_pct;
  int                             rx_hold_len;
  int                             idle_cycles;
  logic [dtq_pkg::TIME_BITS-1:0]  clock_now;

  deadline_timer_queue i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .now            (now),
    .delay          (delay),
    .callback_id    (callback_id),
    .handle         (handle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .slot           (slot),
    .fired          (fired),
    .fired_callback (fired_callback)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one operation to the shadow table and return the answer it gives.
  function automatic timer_result_t timer_table_step(
      input logic [1:0]                    op,
      input logic [dtq_pkg::TIME_BITS-1:0] t_now,
      input logic [dtq_pkg::DELAY_W-1:0]   dly,
      input logic [dtq_pkg::CB_W-1:0]      cb,
      input logic [dtq_pkg::IDX_W-1:0]     hdl);
    timer_result_t                 r;
    logic [dtq_pkg::TIME_BITS-1:0] dl;
    int                            s;
    int                            pos;
    r = '0;
    case (op)
      dtq_pkg::OP_ADD: begin
        s = 0;
        while (s < dtq_pkg::MAX_TIMERS && slot_used[s]) s++;
        if (s == dtq_pkg::MAX_TIMERS) begin
          r.status = dtq_pkg::ST_FULL;
        end else begin
          dl = t_now + dtq_pkg::TIME_BITS'(dly);
          pos = 0;
          // Later arrivals go behind every equal deadline.
          while (pos < deadline_order.size() &&
                 slot_deadline[deadline_order[pos]] <= dl) pos++;
          deadline_order.insert(pos, dtq_pkg::IDX_W'(s));
          slot_used[s]     = 1'b1;
          slot_deadline[s] = dl;
          slot_callback[s] = cb;
          r.slot           = dtq_pkg::IDX_W'(s);
        end
      end
      dtq_pkg::OP_CANCEL: begin
        if (!slot_used[hdl]) begin
          r.status = dtq_pkg::ST_UNUSED;
        end else begin
          for (pos = 0; pos < deadline_order.size(); pos++) begin
            if (deadline_order[pos] == hdl) begin
              deadline_order.delete(pos);
              break;
            end
          end
          slot_used[hdl] = 1'b0;
        end
      end
      dtq_pkg::OP_POLL: begin
        // Only the head can fire, and only once it is due.
        if (deadline_order.size() > 0 &&
            slot_deadline[deadline_order[0]] <= t_now) begin
          r.fired    = 1'b1;
          r.slot     = deadline_order[0];
          r.fired_cb = slot_callback[deadline_order[0]];
          slot_used[deadline_order[0]] = 1'b0;
          deadline_order.delete(0);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one beat, wait for it to be taken, and record its answer.
  task automatic send_beat(input logic [1:0] op,
                           input logic [dtq_pkg::TIME_BITS-1:0] t_now,
                           input logic [dtq_pkg::DELAY_W-1:0] dly,
                           input logic [dtq_pkg::CB_W-1:0] cb,
                           input logic [dtq_pkg::IDX_W-1:0] hdl);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    now         <= t_now;
    delay       <= dly;
    callback_id <= cb;
    handle      <= hdl;
    do @(posedge clk); while (!in_ready);
    timer_answers.push_back(timer_table_step(op, t_now, dly, cb, hdl));
  endtask

  // Stop offering and let every outstanding answer come back.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (timer_answers.size() != 0) @(posedge clk);
    repeat (LAT_PAUSE) @(posedge clk);
  endtask

  // Empty queue: poll with nothing pending, cancel of a free handle, and
  // the undefined opcode.
  task automatic test_empty_queue();
    send_beat(dtq_pkg::OP_POLL, '0, '0, '0, '0);
    send_beat(dtq_pkg::OP_CANCEL, '1, '1, '1, '1);
    send_beat(OP_UNDEF, '1, '1, '1, '0);
    wait_drain();
  endtask

  // Deadline ordering: wrapped deadline, not-yet-due head, equal deadlines,
  // a full table, cancel of a live and then a freed handle, and a due head.
  task automatic test_deadline_order();
    int i;
    send_beat(dtq_pkg::OP_ADD, '1, '1, '1, '0);
    send_beat(dtq_pkg::OP_POLL, 32'h0000_FFFD, '0, '0, '0);
    for (i = 0; i < dtq_pkg::MAX_TIMERS - 1; i++) begin
      if (i == 0) begin
        send_beat(dtq_pkg::OP_ADD, '0, '0, '0, dtq_pkg::IDX_W'($urandom));
      end else if (i < 3) begin
        send_beat(dtq_pkg::OP_ADD, 32'd500, 16'd20, dtq_pkg::CB_W'(8'h11 * i),
                  dtq_pkg::IDX_W'($urandom));
      end else begin
        send_beat(dtq_pkg::OP_ADD, dtq_pkg::TIME_BITS'($urandom_range(100000)),
                  dtq_pkg::DELAY_W'($urandom), dtq_pkg::CB_W'($urandom),
                  dtq_pkg::IDX_W'($urandom));
      end
    end
    send_beat(dtq_pkg::OP_ADD, 32'd7, 16'd7, 8'hA5, '0);
    send_beat(dtq_pkg::OP_CANCEL, '0, '0, '0, dtq_pkg::IDX_W'(7));
    send_beat(dtq_pkg::OP_CANCEL, '0, '0, '0, dtq_pkg::IDX_W'(7));
    send_beat(dtq_pkg::OP_POLL, '1, '0, '0, '0);
    wait_drain();
  endtask

  // The receiver holds off for a long stretch while beats keep coming, so
  // the result path fills and the input stalls.
  task automatic test_rx_backpressure();
    int k;
    send_idle_pct = 0;
    rx_stall_pct  = 0;
    rx_hold_len   = HOLD_CYCLES;
    for (k = 0; k < 30; k++) begin
      if (k % 3 == 2) begin
        send_beat(dtq_pkg::OP_POLL,
                  clock_now + dtq_pkg::TIME_BITS'($urandom_range(2000)),
                  dtq_pkg::DELAY_W'($urandom), dtq_pkg::CB_W'($urandom),
                  dtq_pkg::IDX_W'($urandom));
      end else begin
        send_beat(dtq_pkg::OP_ADD, clock_now, dtq_pkg::DELAY_W'($urandom_range(1000)),
                  dtq_pkg::CB_W'($urandom), dtq_pkg::IDX_W'($urandom));
      end
    end
    wait_drain();
  endtask

  // Random traffic around an advancing clock, in stretches that lean
  // toward filling the table or draining it.
  task automatic test_random_traffic(input int n_items);
    int                            k;
    int                            pick;
    int                            h;
    bit                            fill_bias;
    int                            live[$];
    logic [dtq_pkg::DELAY_W-1:0]   dly;
    logic [dtq_pkg::TIME_BITS-1:0] t;
    for (k = 0; k < n_items; k++) begin
      if (k % 40 == 0) fill_bias = 1'($urandom_range(1));
      // Advance the clock; now and then jump anywhere in the time range.
      case ($urandom_range(99)) inside
        [0:59]:  clock_now = clock_now + dtq_pkg::TIME_BITS'($urandom_range(20));
        [60:89]: ;
        [90:98]: clock_now = clock_now + dtq_pkg::TIME_BITS'($urandom_range(2000));
        default: clock_now = dtq_pkg::TIME_BITS'($urandom);
      endcase
      pick = $urandom_range(99);
      if (!fill_bias) pick = pick < 50 ? pick / 2 : pick;
      if (pick < (fill_bias ? 65 : 25)) begin
        case ($urandom_range(9))
          0:       dly = dtq_pkg::DELAY_W'($urandom);
          1, 2:    dly = dtq_pkg::DELAY_W'($urandom_range(3) * 32);
          default: dly = dtq_pkg::DELAY_W'($urandom_range(300));
        endcase
        send_beat(dtq_pkg::OP_ADD, clock_now, dly, dtq_pkg::CB_W'($urandom),
                  dtq_pkg::IDX_W'($urandom));
      end else if (pick < 75) begin
        live.delete();
        for (h = 0; h < dtq_pkg::MAX_TIMERS; h++) if (slot_used[h]) live.push_back(h);
        if (live.size() > 0 && $urandom_range(99) < 85) begin
          h = live[$urandom_range(live.size() - 1)];
        end else begin
          h = $urandom_range(dtq_pkg::MAX_TIMERS - 1);
        end
        send_beat(dtq_pkg::OP_CANCEL, dtq_pkg::TIME_BITS'($urandom),
                  dtq_pkg::DELAY_W'($urandom), dtq_pkg::CB_W'($urandom),
                  dtq_pkg::IDX_W'(h));
      end else if (pick < 96) begin
        t = ($urandom_range(19) == 0) ? dtq_pkg::TIME_BITS'($urandom) : clock_now;
        send_beat(dtq_pkg::OP_POLL, t, dtq_pkg::DELAY_W'($urandom),
                  dtq_pkg::CB_W'($urandom), dtq_pkg::IDX_W'($urandom));
      end else begin
        send_beat(OP_UNDEF, dtq_pkg::TIME_BITS'($urandom), dtq_pkg::DELAY_W'($urandom),
                  dtq_pkg::CB_W'($urandom), dtq_pkg::IDX_W'($urandom));
      end
    end
    wait_drain();
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (rx_hold_len > 0) begin
      out_ready <= 1'b0;
      rx_hold_len = rx_hold_len - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic report_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, exp_val, act_val);
      err_cnt++;
    end
  endtask

  // Compare each result beat with the oldest outstanding answer.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (timer_answers.size() == 0) begin
        $display("%0t: result beat with no answer pending: status %0d slot %0d",
                 $realtime, status, slot);
        err_cnt++;
      end else begin
        got = timer_answers.pop_front();
        if ({status, slot, fired, fired_callback} !== got) begin
          report_field("status", int'(got.status), int'(status));
          report_field("slot", int'(got.slot), int'(slot));
          report_field("fired", int'(got.fired), int'(fired));
          report_field("fired_callback", int'(got.fired_cb), int'(fired_callback));
          if ($isunknown({status, slot, fired, fired_callback})) begin
            $display("%0t: unknown bits in result beat: expected %h, got %h",
                     $realtime, got, {status, slot, fired, fired_callback});
            err_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: too long without any beat moving on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $realtime, IDLE_LIMIT);
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    err_cnt       = 0;
    idle_cycles   = 0;
    rx_hold_len   = 0;
    send_idle_pct = 0;
    rx_stall_pct  = 0;
    clock_now     = dtq_pkg::TIME_BITS'($urandom);
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_deadline_order();
    test_rx_backpressure();

    send_idle_pct = 0;
    rx_stall_pct  = 0;
    test_random_traffic(RANDOM_PER_PHASE);
    send_idle_pct = 49;
    rx_stall_pct  = 0;
    test_random_traffic(RANDOM_PER_PHASE);
    send_idle_pct = 0;
    rx_stall_pct  = 49;
    test_random_traffic(RANDOM_PER_PHASE);
    send_idle_pct = 13;
    rx_stall_pct  = 13;
    test_random_traffic(RANDOM_PER_PHASE);

    if (err_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

### deadline_timer_queue.f
hw/rtl/dtq_pkg.sv
hw/rtl/deadline_timer_queue.sv
verif/tb.sv
